/* rtl/stroke_segment_interpolator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Stroke segment interpolator assertion macros
// Clocked property checks with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef STROKE_SEGMENT_INTERPOLATOR_UNIT_ASSERT_SVH
`define STROKE_SEGMENT_INTERPOLATOR_UNIT_ASSERT_SVH

// check a property on each rising edge, masked while reset is high
`define SSI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on each rising edge, reset included
`define SSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// Stroke segment interpolator package
// Field widths, fixed point constants, command and register codes, states.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int MAX_STEPS_DEF = 64;

  localparam int POS_W      = 12;
  localparam int PT_W       = 13;
  localparam int PW_W       = 14;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CMD_W      = 2;

  localparam int OFFSET     = 10;
  localparam int FRAC       = 8;
  localparam int HALF       = 128;
  localparam int ONE        = 256;

  localparam int MAG_W      = 14;
  localparam int DIVIDEND_W = MAG_W + 1;
  localparam int ITER_W     = $clog2(MAG_W + 1);
  localparam int XQ_W       = PT_W + 1;
  localparam int WQ_W       = PW_W + 2;
  localparam int NUMR_W     = PW_W + 1 - FRAC;

  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 13'd480;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIVX,
    S_DIVY,
    S_GEN,
    S_DIVW,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_t;

endpackage

/* rtl/ssi_div.sv */
// ----------------------------------------------------------------------------
// Stroke segment interpolator divider
// Restoring divider, one quotient bit per cycle, floor quotient and remainder.
// ----------------------------------------------------------------------------
module ssi_div #(
  parameter int DW = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [ssi_pkg::DIVIDEND_W-1:0] dividend,
  input  logic        [DW-1:0]                  divisor,
  output logic                                  done,
  output logic signed [ssi_pkg::DIVIDEND_W-1:0] quot,
  output logic        [DW-1:0]                  rem
);
  import ssi_pkg::*;

  logic                  busy;
  logic [ITER_W-1:0]     count;
  logic [MAG_W-1:0]      quo;
  logic [DW-1:0]         part;
  logic [DW-1:0]         dvs;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [DW:0]           shifted;
  logic [DW:0]           diff;
  logic                  ge;
  logic [DIVIDEND_W-1:0] qpos;

  assign mag     = dividend[DIVIDEND_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
  assign shifted = {part, quo[MAG_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};
  assign done    = busy && (count == '0);
  assign qpos    = {1'b0, quo};
  assign quot    = neg ? $signed(-qpos - DIVIDEND_W'(part != '0)) : $signed(qpos);
  assign rem     = (neg && (part != '0)) ? dvs - part : part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= ITER_W'(MAG_W);
    end else if (busy) begin
      if (count != '0) begin
        count <= count - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= mag;
      part <= '0;
      dvs  <= divisor;
      neg  <= dividend[DIVIDEND_W-1];
    end else if (busy && (count != '0)) begin
      part <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo  <= {quo[MAG_W-2:0], ge};
    end
  end

endmodule

/* rtl/stroke_segment_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// Stroke segment interpolator
// Turns pen events into stroke points, cutting a segment into evenly spaced
// points with ramped widths when the pen width changes by more than one half.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     cmd pos_x pos_y pen_width
//   out      output     out_valid/out_ready   point_x point_y point_width
//                                             stroke_start last
//   cfg      input      cfg_en                cfg_index cfg_data
//
// An event with no point leaves the sequencer in S_IDLE; one with a single
// point passes through S_SINGLE, plus any wait for the output slot. A cut
// segment uses the shared divider three times, then walks its num steps in
// S_GEN and emits each stored point through S_EMIT_RD and S_EMIT_PUT.
// The sequencer takes no request until the last point of an event is loaded.
// Reset is synchronous; out_ready low holds a valid output register and the emit, not the walk.
// ----------------------------------------------------------------------------
module stroke_segment_interpolator_unit #(
  parameter int MAX_STEPS = ssi_pkg::MAX_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [ssi_pkg::CMD_W-1:0]     cmd,
  input  logic        [ssi_pkg::POS_W-1:0]     pos_x,
  input  logic        [ssi_pkg::POS_W-1:0]     pos_y,
  input  logic        [ssi_pkg::PW_W-1:0]      pen_width,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ssi_pkg::PT_W-1:0]      point_x,
  output logic signed [ssi_pkg::PT_W-1:0]      point_y,
  output logic        [ssi_pkg::PW_W-1:0]      point_width,
  output logic                                 stroke_start,
  output logic                                 last,
  input  logic                                 cfg_en,
  input  logic        [ssi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [ssi_pkg::CFG_W-1:0]     cfg_data
);
  import ssi_pkg::*;

  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int AW = $clog2(MAX_STEPS);

  state_t state, state_next;

  logic [CFG_W-1:0]      canvas_w, canvas_h;
  logic                  pen_down;
  logic [PT_W-1:0]       last_x, last_y;
  logic [PW_W-1:0]       previous_width, current_width;

  logic [PT_W-1:0]       pend_x, pend_y;
  logic [PW_W-1:0]       pend_w;
  logic                  pend_start;

  logic [XQ_W-1:0]       seg_x, seg_y;
  logic [DIVIDEND_W-1:0] seg_dy, seg_d;
  logic [CW-1:0]         num, k, cnt, idx;
  logic [XQ_W-1:0]       ax_q, ay_q, qdx, qdy;
  logic [CW-1:0]         ax_r, ay_r, rdx, rdy;
  logic [WQ_W-1:0]       wq, qdw;
  logic [CW-1:0]         wr, rdw;

  logic [PT_W-1:0]       mem_x [MAX_STEPS];
  logic [PT_W-1:0]       mem_y [MAX_STEPS];
  logic [PT_W-1:0]       rd_x, rd_y;

  logic                  accept, slot_free, in_canvas, same, cut;
  logic                  ev_press_ok, ev_move_ok, ev_first, ev_cut, ev_single;
  logic [PT_W-1:0]       nx, ny;
  logic [XQ_W-1:0]       dx, dy;
  logic [DIVIDEND_W-1:0] dw;
  logic [PW_W-1:0]       ad;
  logic [PW_W:0]         numsum;
  logic [NUMR_W-1:0]     num_raw;
  logic [CW-1:0]         num_c;

  logic [XQ_W-1:0]       gx, gy;
  logic                  mem_we, gen_end, emit_last;
  logic [CW-1:0]         cnt_next;
  logic [CW:0]           sx_r, sy_r, sw_r;
  logic                  cx, cy, cw;
  logic [WQ_W-1:0]       wsum;

  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_a;
  logic [CW-1:0]         div_b;
  logic signed [DIVIDEND_W-1:0] div_q;
  logic [CW-1:0]         div_r;

  logic                  load_single, load_emit;

  ssi_div #(
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(div_a)),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // event decode
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign in_canvas = ({1'b0, pos_x} < canvas_w) && ({1'b0, pos_y} < canvas_h);
  assign nx        = {1'b0, pos_x} - PT_W'(OFFSET);
  assign ny        = {1'b0, pos_y} - PT_W'(OFFSET);
  assign same      = (nx == last_x) && (ny == last_y);
  assign dx        = {nx[PT_W-1], nx} - {last_x[PT_W-1], last_x};
  assign dy        = {ny[PT_W-1], ny} - {last_y[PT_W-1], last_y};
  assign dw        = {1'b0, pen_width} - {1'b0, current_width};
  assign ad        = dw[DIVIDEND_W-1] ? PW_W'(-dw) : PW_W'(dw);
  assign cut       = ad > PW_W'(HALF);
  assign numsum    = {1'b0, ad} + (PW_W + 1)'(HALF + ONE);
  assign num_raw   = numsum[PW_W:FRAC];
  assign num_c     = (num_raw > NUMR_W'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(num_raw);

  assign ev_press_ok = (cmd == CMD_PRESS) && in_canvas && !pen_down;
  assign ev_move_ok  = (cmd == CMD_MOVE) && in_canvas && !same && pen_down;
  assign ev_first    = ev_move_ok && (current_width == '0);
  assign ev_cut      = ev_move_ok && !ev_first && cut;
  assign ev_single   = ev_press_ok || (ev_move_ok && !ev_cut);

  // step walk: floor quotient and remainder, turned into truncation
  assign gx   = ax_q + XQ_W'((ax_r != '0) && ax_q[XQ_W-1]);
  assign gy   = ay_q + XQ_W'((ay_r != '0) && ay_q[XQ_W-1]);
  assign sx_r = {1'b0, ax_r} + {1'b0, rdx};
  assign sy_r = {1'b0, ay_r} + {1'b0, rdy};
  assign cx   = sx_r >= {1'b0, num};
  assign cy   = sy_r >= {1'b0, num};
  assign sw_r = {1'b0, wr} + {1'b0, rdw};
  assign cw   = sw_r >= {1'b0, cnt};
  assign wsum = {2'b0, previous_width} + wq + WQ_W'((wr != '0) && wq[WQ_W-1]);

  assign gen_end   = (k == num);
  assign cnt_next  = cnt + CW'(mem_we);
  assign emit_last = (CW'(idx + 1'b1) == cnt);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && ev_cut) begin
          state_next = S_DIVX;
        end else if (accept && ev_single) begin
          state_next = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (slot_free) state_next = S_IDLE;
      end
      S_DIVX: begin
        if (div_done) state_next = S_DIVY;
      end
      S_DIVY: begin
        if (div_done) state_next = S_GEN;
      end
      S_GEN: begin
        if (gen_end) state_next = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (slot_free) state_next = emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    div_start   = 1'b0;
    div_a       = {dx[XQ_W-1], dx};
    div_b       = num_c;
    mem_we      = 1'b0;
    load_single = 1'b0;
    load_emit   = 1'b0;
    case (state)
      S_IDLE: begin
        div_start = accept && ev_cut;
      end
      S_SINGLE: begin
        load_single = slot_free;
      end
      S_DIVX: begin
        div_start = div_done;
        div_a     = seg_dy;
        div_b     = num;
      end
      S_GEN: begin
        mem_we    = (gx != seg_x) || (gy != seg_y);
        div_start = gen_end;
        div_a     = seg_d;
        div_b     = cnt_next;
      end
      S_EMIT_PUT: begin
        load_emit = slot_free;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      canvas_w       <= CANVAS_WIDTH_RST;
      canvas_h       <= CANVAS_HEIGHT_RST;
      pen_down       <= 1'b0;
      last_x         <= '0;
      last_y         <= '0;
      previous_width <= '0;
      current_width  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_en) begin
        case (cfg_index)
          REG_CANVAS_WIDTH:  canvas_w <= cfg_data;
          REG_CANVAS_HEIGHT: canvas_h <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (ev_press_ok) begin
          pen_down       <= 1'b1;
          previous_width <= '0;
          current_width  <= '0;
        end else if (cmd == CMD_RELEASE) begin
          pen_down <= 1'b0;
        end else if ((cmd == CMD_MOVE) && !in_canvas) begin
          pen_down <= 1'b0;
        end
        if (ev_press_ok || ((cmd == CMD_MOVE) && in_canvas)) begin
          last_x <= nx;
          last_y <= ny;
        end
        if (ev_move_ok) begin
          previous_width <= current_width;
          current_width  <= pen_width;
        end
      end
      if (load_single || load_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_x     <= nx;
      pend_y     <= ny;
      pend_w     <= ev_press_ok ? '0 : pen_width;
      pend_start <= ev_press_ok;
      seg_x      <= {last_x[PT_W-1], last_x};
      seg_y      <= {last_y[PT_W-1], last_y};
      seg_dy     <= {dy[XQ_W-1], dy};
      seg_d      <= dw;
      num        <= num_c;
    end
    if ((state == S_DIVX) && div_done) begin
      qdx <= div_q[XQ_W-1:0];
      rdx <= div_r;
    end
    if ((state == S_DIVY) && div_done) begin
      qdy  <= div_q[XQ_W-1:0];
      rdy  <= div_r;
      ax_q <= seg_x + qdx;
      ax_r <= rdx;
      ay_q <= seg_y + div_q[XQ_W-1:0];
      ay_r <= div_r;
      k    <= CW'(1);
      cnt  <= '0;
    end
    if (state == S_GEN) begin
      if (mem_we) begin
        mem_x[cnt[AW-1:0]] <= gx[PT_W-1:0];
        mem_y[cnt[AW-1:0]] <= gy[PT_W-1:0];
        seg_x <= gx;
        seg_y <= gy;
      end
      cnt  <= cnt_next;
      ax_q <= ax_q + qdx + XQ_W'(cx);
      ax_r <= cx ? CW'(sx_r - {1'b0, num}) : CW'(sx_r);
      ay_q <= ay_q + qdy + XQ_W'(cy);
      ay_r <= cy ? CW'(sy_r - {1'b0, num}) : CW'(sy_r);
      k    <= k + 1'b1;
    end
    if ((state == S_DIVW) && div_done) begin
      wq  <= {div_q[DIVIDEND_W-1], div_q};
      qdw <= {div_q[DIVIDEND_W-1], div_q};
      wr  <= div_r;
      rdw <= div_r;
      idx <= '0;
    end
    rd_x <= mem_x[idx[AW-1:0]];
    rd_y <= mem_y[idx[AW-1:0]];
    if (load_emit) begin
      wq  <= wq + qdw + WQ_W'(cw);
      wr  <= cw ? CW'(sw_r - {1'b0, cnt}) : CW'(sw_r);
      idx <= idx + 1'b1;
    end
    if (load_single) begin
      point_x      <= pend_x;
      point_y      <= pend_y;
      point_width  <= pend_w;
      stroke_start <= pend_start;
      last         <= 1'b1;
    end else if (load_emit) begin
      point_x      <= rd_x;
      point_y      <= rd_y;
      point_width  <= wsum[PW_W-1:0];
      stroke_start <= 1'b0;
      last         <= emit_last;
    end
  end

endmodule

/* rtl/ssi_checker.sv */
// ----------------------------------------------------------------------------
// Stroke segment interpolator checker
// Port level checks on the output register, stroke starts and reset.
// ----------------------------------------------------------------------------
`include "stroke_segment_interpolator_unit_assert.svh"

module ssi_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ssi_pkg::PT_W-1:0]      point_x,
  input logic signed [ssi_pkg::PT_W-1:0]      point_y,
  input logic        [ssi_pkg::PW_W-1:0]      point_width,
  input logic                                 stroke_start,
  input logic                                 last
);

  `SSI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y) && $stable(point_width) && $stable(last), "stalled point changed")
  `SSI_ASSERT(a_start_last, clk, rst, out_valid && stroke_start |-> last, "stroke start point is not the only point of its request")
  `SSI_ASSERT(a_start_width, clk, rst, out_valid && stroke_start |-> point_width == '0, "stroke start point has nonzero width")
  `SSI_ASSERT(a_busy_walk, clk, rst, out_valid && !last |-> !in_ready, "request taken while a segment is still being emitted")
  `SSI_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid && in_ready, "reset left the block busy")

endmodule

bind stroke_segment_interpolator_unit ssi_checker u_ssi_checker (.*);
